FILE: rtl/wfba_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Worst-fit block allocator package
// Shared widths, defaults and action codes for the allocator.
// ---------------------------------------------------------------------------
package wfba_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_BLOCKS_DEF = 16;
    localparam int SIZE_BITS_DEF  = 16;

    // Fixed field widths of the input and result words.
    localparam int TAG_W = 8;
    localparam int AMT_W = 16;

    // Action codes carried on the input word.
    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_ALLOC = 1'b1;

endpackage

FILE: rtl/wfba_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, with the read data registered.
// ---------------------------------------------------------------------------
module wfba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/worst_fit_block_allocator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Worst-fit block allocator
// Keeps a table of free blocks (tag and size) in one RAM. An add word appends
// a block; an allocate word scans the table for the largest block that fits,
// zeroes its size and returns its tag and old size.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                   Fields
//  --------  ---------  --------------------------  ---------------------------
//  input     in         i_in_valid / o_in_ready     i_action, i_block_tag,
//                                                   i_amount
//  result    out        o_out_valid / i_out_ready   o_granted, o_chosen_tag,
//                                                   o_chosen_size, o_table_full
//
//  An add word goes straight to the finish state, which loads the result
//  register. An allocate word first reads each stored entry through the
//  single read port and compares the registered read data, then writes the
//  chosen entry back, and then the result is loaded. On an empty table there
//  is no read, and the word goes straight to the write-back.
//  Reset is synchronous and active low; it empties the table at once.
//  A new word is accepted while a finished result still waits to be taken;
//  a further result waits in the finish state until the output is free.
//
module worst_fit_block_allocator
    import wfba_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_action,
    input  logic [TAG_W-1:0] i_block_tag,
    input  logic [AMT_W-1:0] i_amount,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_granted,
    output logic [TAG_W-1:0] o_chosen_tag,
    output logic [AMT_W-1:0] o_chosen_size,
    output logic             o_table_full
);

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int ENT_W = TAG_W + SIZE_BITS;

    // Controller states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_WB   = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]           r_state, n_state;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     r_idx;
    logic [CNT_W-1:0]     r_rd_idx;
    logic                 r_rd_vld;
    logic [SIZE_BITS-1:0] r_amount;
    logic                 r_found;
    logic [IDX_W-1:0]     r_best_idx;
    logic [TAG_W-1:0]     r_best_tag;
    logic [SIZE_BITS-1:0] r_best_size;
    logic                 r_full;
    logic                 r_out_vld;
    logic                 r_granted;
    logic [TAG_W-1:0]     r_tag_out;
    logic [AMT_W-1:0]     r_size_out;
    logic                 r_full_out;

    logic                 in_acc;
    logic                 tbl_full;
    logic                 issue;
    logic                 last_cmp;
    logic                 fits;
    logic                 out_free;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [ENT_W-1:0]     ram_wdata;
    logic [ENT_W-1:0]     ram_rdata;
    logic [TAG_W-1:0]     rd_tag;
    logic [SIZE_BITS-1:0] rd_size;

    // Table storage: tag in the upper bits, size in the lower bits.
    wfba_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_BLOCKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (issue),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign rd_tag  = ram_rdata[ENT_W-1:SIZE_BITS];
    assign rd_size = ram_rdata[SIZE_BITS-1:0];

    // Handshake and scan control.
    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign tbl_full   = (r_count == CNT_W'(MAX_BLOCKS));
    assign issue      = (r_state == S_SCAN) && (r_idx < r_count);
    assign last_cmp   = r_rd_vld && (r_rd_idx == r_count - CNT_W'(1));
    assign fits       = (rd_size >= r_amount) && (!r_found || (rd_size > r_best_size));
    assign out_free   = !r_out_vld || i_out_ready;

    // RAM writes: an append on an accepted add, or the zeroing write-back.
    // Reads happen only in the scan state, so they never meet a write.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_best_idx;
        ram_wdata = {r_best_tag, {SIZE_BITS{1'b0}}};
        if (r_state == S_IDLE) begin
            ram_we    = in_acc && (i_action == ACT_ADD) && !tbl_full;
            ram_waddr = r_count[IDX_W-1:0];
            ram_wdata = {i_block_tag, SIZE_BITS'(i_amount)};
        end else if (r_state == S_WB) begin
            ram_we = r_found;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_action == ACT_ADD) begin
                        n_state = S_DONE;
                    end else if (r_count == '0) begin
                        n_state = S_WB;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (last_cmp) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= issue;
            if (in_acc) begin
                r_idx <= '0;
            end else if (issue) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (ram_we && (r_state == S_IDLE)) begin
                r_count <= r_count + CNT_W'(1);
            end
            if ((r_state == S_DONE) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Scan datapath: keep the first of the largest fitting entries.
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_idx <= r_idx;
        end
        if (in_acc) begin
            r_amount <= SIZE_BITS'(i_amount);
            r_found  <= 1'b0;
            r_full   <= (i_action == ACT_ADD) && tbl_full;
        end else if (r_rd_vld && fits) begin
            r_found     <= 1'b1;
            r_best_idx  <= r_rd_idx[IDX_W-1:0];
            r_best_tag  <= rd_tag;
            r_best_size <= rd_size;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_granted  <= r_found;
            r_tag_out  <= r_found ? r_best_tag : '0;
            r_size_out <= r_found ? AMT_W'(r_best_size) : '0;
            r_full_out <= r_full;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_granted     = r_granted;
    assign o_chosen_tag  = r_tag_out;
    assign o_chosen_size = r_size_out;
    assign o_table_full  = r_full_out;

    // The table never holds more entries than it has room for.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_BLOCKS))
        else $error("entry count beyond table depth");

    // Reads and writes of the RAM never fall in the same cycle.
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |-> !ram_we)
        else $error("RAM read and write in the same cycle");

    // A scan compare is only ever pending while scanning.
    a_cmp_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == S_SCAN))
        else $error("read data returned outside the scan");

    // Write-back follows a scan, or an allocate on an empty table.
    a_wb_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB) |-> $past(r_state == S_SCAN || r_state == S_IDLE))
        else $error("write-back entered from the wrong state");

    // A grant and a refused add are never reported together.
    a_grant_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_granted && o_table_full))
        else $error("grant and table full in one result");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Worst-fit block allocator testbench
// Drives add and allocate words into the allocator and predicts each result
// word from its own copy of the free-block table. Every result is compared
// field by field with the oldest prediction. A short directed sequence covers
// the corner cases, then random words run with random idling on both sides.
// ---------------------------------------------------------------------------
module tb;
    import wfba_pkg::*;

    localparam int SLOTS        = MAX_BLOCKS_DEF;
    localparam int SZ_W         = SIZE_BITS_DEF;
    localparam int RANDOM_WORDS = 1950;
    localparam int QUIET_TAIL   = 200;
    localparam int STUCK_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 64;

    // One result word as the allocator presents it.
    typedef struct packed {
        logic             granted;
        logic [TAG_W-1:0] tag;
        logic [AMT_W-1:0] size;
        logic             full;
    } t_reply;

    // Table of free blocks and the queue of result words still to arrive.
    class worst_fit_scoreboard;
        logic [TAG_W-1:0] tags  [SLOTS];
        logic [SZ_W-1:0]  sizes [SLOTS];
        int unsigned      used;
        t_reply           replies_due[$];
        int unsigned      errors;

        function new();
            used   = 0;
            errors = 0;
        endfunction

        // Applies an accepted word to the table and queues the reply it causes.
        function void predict_reply(logic act, logic [TAG_W-1:0] tag,
                                    logic [AMT_W-1:0] amt);
            t_reply          r;
            logic [SZ_W-1:0] want;
            logic [SZ_W-1:0] best_size;
            bit              found;
            int unsigned     best;
            r         = '0;
            want      = amt[SZ_W-1:0];
            found     = 1'b0;
            best      = 0;
            best_size = '0;
            if (act == ACT_ADD) begin
                if (used >= SLOTS) begin
                    r.full = 1'b1;
                end else begin
                    tags[used]  = tag;
                    sizes[used] = want;
                    used++;
                end
            end else begin
                // Largest fitting block; a strict compare keeps the first of equals.
                for (int i = 0; i < used; i++) begin
                    if (sizes[i] >= want && (!found || sizes[i] > best_size)) begin
                        found     = 1'b1;
                        best      = i;
                        best_size = sizes[i];
                    end
                end
                if (found) begin
                    r.granted   = 1'b1;
                    r.tag       = tags[best];
                    r.size      = AMT_W'(best_size);
                    sizes[best] = '0;
                end
            end
            replies_due.push_back(r);
        endfunction

        function void flag_field(string field, longint want, longint got);
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
        endfunction

        // Compares one accepted result word with the oldest prediction.
        function void check_result(t_reply got);
            t_reply want;
            if (replies_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = replies_due.pop_front();
            if (got.granted !== want.granted) flag_field("granted", want.granted, got.granted);
            if (got.tag !== want.tag) flag_field("chosen_tag", want.tag, got.tag);
            if (got.size !== want.size) flag_field("chosen_size", want.size, got.size);
            if (got.full !== want.full) flag_field("table_full", want.full, got.full);
        endfunction

        function int pending();
            return replies_due.size();
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    logic             i_action;
    logic [TAG_W-1:0] i_block_tag;
    logic [AMT_W-1:0] i_amount;
    logic             o_out_valid;
    logic             i_out_ready;
    logic             o_granted;
    logic [TAG_W-1:0] o_chosen_tag;
    logic [AMT_W-1:0] o_chosen_size;
    logic             o_table_full;

    worst_fit_scoreboard board = new();
    bit                  calm;
    int                  stuck_cycles;

    worst_fit_block_allocator uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_block_tag  (i_block_tag),
        .i_amount     (i_amount),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_granted    (o_granted),
        .o_chosen_tag (o_chosen_tag),
        .o_chosen_size(o_chosen_size),
        .o_table_full (o_table_full)
    );

    always #4 i_clk = ~i_clk;

    // Offers one word, with an optional idle burst first, and waits for it to go in.
    task automatic send_word(input logic act, input logic [TAG_W-1:0] tag,
                             input logic [AMT_W-1:0] amt);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_action    <= act;
        i_block_tag <= tag;
        i_amount    <= amt;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.predict_reply(act, tag, amt);
    endtask

    // Picks a request size: zero, a live block size, a small or a wide value.
    function automatic logic [AMT_W-1:0] pick_request();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return AMT_W'(board.sizes[$urandom_range(0, board.used - 1)]);
            2: return AMT_W'($urandom_range(0, 255));
            default: return AMT_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Result side: ready drops in random bursts except in calm stretches.
    initial begin : result_side
        int n;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 9);
                i_out_ready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    // Every accepted result word is checked at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_result('{o_granted, o_chosen_tag, o_chosen_size, o_table_full});
        end
    end

    // Watchdog: too long without any word moving ends the run.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        logic             act;
        logic [TAG_W-1:0] tag;
        logic [AMT_W-1:0] amt;
        calm         = 1'b0;
        stuck_cycles = 0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_action     = ACT_ADD;
        i_block_tag  = '0;
        i_amount     = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Allocate from an empty table gets no fit.
        send_word(ACT_ALLOC, 8'hA5, 16'd0);
        // Tag zero, the extreme sizes, equal largest blocks and a repeated tag.
        send_word(ACT_ADD, 8'h00, 16'd100);
        send_word(ACT_ADD, 8'hFF, 16'hFFFF);
        send_word(ACT_ADD, 8'h55, 16'hFFFF);
        send_word(ACT_ADD, 8'hFF, 16'd0);
        // The first of the two largest wins, then the second, then nothing fits.
        send_word(ACT_ALLOC, 8'h00, 16'hFFFF);
        send_word(ACT_ALLOC, 8'h5A, 16'hFFFF);
        send_word(ACT_ALLOC, 8'hFF, 16'hFFFF);
        // The tag-zero block is granted; then zero requests take emptied blocks.
        send_word(ACT_ALLOC, 8'h00, 16'd1);
        send_word(ACT_ALLOC, 8'h00, 16'd0);
        send_word(ACT_ALLOC, 8'hFF, 16'd0);
        // Fill the rest of the table, then add once more to a full table.
        for (int i = 4; i < SLOTS; i++) begin
            amt = (i == 4) ? 16'd1 : (i == 5) ? 16'hFFFE : AMT_W'($urandom_range(0, 65535));
            send_word(ACT_ADD, TAG_W'(i * 21 + 1), amt);
        end
        send_word(ACT_ADD, 8'h5A, 16'hAAAA);
        send_word(ACT_ALLOC, 8'h00, 16'd2);

        // Random words, mostly allocates, with calm stretches and a calm tail.
        for (int k = 0; k < RANDOM_WORDS; k++) begin
            calm = (k % 400 < 100) || (k >= RANDOM_WORDS - QUIET_TAIL);
            tag  = TAG_W'($urandom_range(0, 255));
            if ($urandom_range(0, 4) == 0) begin
                act = ACT_ADD;
                amt = AMT_W'($urandom_range(0, 65535));
            end else begin
                act = ACT_ALLOC;
                amt = pick_request();
            end
            send_word(act, tag, amt);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // Drain the outstanding results, then watch for anything extra.
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
